// ===== hdl/addressed_frame_deframer_crc16_core_macros.svh =====
// Assertion macros shared by the deframer modules.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef ADDRESSED_FRAME_DEFRAMER_CRC16_CORE_MACROS_SVH
`define ADDRESSED_FRAME_DEFRAMER_CRC16_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset
`define AFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ===== hdl/afd_pkg.sv =====
// Shared types, codes, constants and the CRC-16 byte update for the deframer.
// No dependencies.
package afd_pkg;

    // Default payload buffer depth in bytes
    localparam int BUF_DEPTH_DEF = 1024;

    // Width used to compare counts against the buffer depth (depth up to 65536)
    localparam int EXT_W = 17;

    localparam logic [7:0]  SYNC_BYTE      = 8'h42;
    localparam logic [7:0]  BROADCAST_ADDR = 8'hFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [7:0]  STATION_RESET  = 8'd20;

    // Word widths on the stream ports
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_ADDR   = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_TYPE   = 3'd4,
        PH_DATA   = 3'd5,
        PH_CRC_LO = 3'd6,
        PH_CRC_HI = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OTHER_ADDR = 2'd1,
        ST_CRC_ERR    = 2'd2,
        ST_OVERLONG   = 2'd3
    } status_t;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic CMD_LINE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // One result in flight between parser and output stage
    typedef struct packed {
        logic        kind;
        status_t     status;
        logic [7:0]  address;
        logic [7:0]  ftype;
        logic [15:0] length;
        logic        rd_zero;   // read outside the buffer returns 0
    } afd_item_t;

    // Payload RAM access request
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } afd_ram_ctl_t;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic [7:0]  d;
        logic        top;
        c = crc;
        d = data;
        for (int i = 0; i < 8; i++)
        begin
            top = c[15] ^ d[7];
            c   = {c[14:0], 1'b0};
            if (top)
            begin
                c = c ^ CRC_POLY;
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hdl/afd_payload_ram.sv =====
// Single-port payload buffer with a registered read port.
// Uses afd_pkg for the access request type.
module afd_payload_ram #(
    parameter int DEPTH = afd_pkg::BUF_DEPTH_DEF,
    parameter int AW    = $clog2(afd_pkg::BUF_DEPTH_DEF)
) (
    input  logic                  clk,
    input  afd_pkg::afd_ram_ctl_t ctl,
    input  logic [AW-1:0]         addr,
    input  logic [7:0]            wdata,
    output logic [7:0]            rdata
);
    import afd_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/afd_parser.sv =====
// Frame parser: phase tracking, header capture, running CRC, status and RAM requests.
// Uses afd_pkg and the assertion macros header.
`include "addressed_frame_deframer_crc16_core_macros.svh"

module afd_parser #(
    parameter int BUF_DEPTH = afd_pkg::BUF_DEPTH_DEF,
    parameter int AW        = $clog2(afd_pkg::BUF_DEPTH_DEF)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    input  logic                  in_fire,
    input  logic                  cmd,
    input  logic [7:0]            rx_byte,
    input  logic [9:0]            read_index,
    output logic                  item_valid,
    output afd_pkg::afd_item_t    item,
    output afd_pkg::afd_ram_ctl_t ram_ctl,
    output logic [AW-1:0]         ram_addr,
    output logic [7:0]            ram_wdata
);
    import afd_pkg::*;

    localparam logic [EXT_W-1:0] DEPTH_W = EXT_W'(BUF_DEPTH);

    phase_t      phase_reg,   phase_next;
    logic [7:0]  station_reg;
    logic [7:0]  addr_reg,    addr_next;
    logic [15:0] length_reg,  length_next;
    logic [7:0]  type_reg,    type_next;
    logic [15:0] count_reg,   count_next;
    logic [15:0] crc_reg,     crc_next;
    logic [7:0]  crc_lo_reg,  crc_lo_next;

    logic [15:0]      crc_upd;
    logic [15:0]      count_inc;
    logic [15:0]      rx_crc;
    logic [EXT_W-1:0] count_w;
    logic [EXT_W-1:0] rd_idx_w;
    logic             rd_in_range;
    logic             line_fire;

    assign line_fire   = in_fire && (cmd == CMD_LINE);
    assign crc_upd     = crc16_byte(crc_reg, rx_byte);
    assign count_inc   = count_reg + 16'd1;
    assign rx_crc      = {rx_byte, crc_lo_reg};
    assign count_w     = {1'b0, count_reg};
    assign rd_idx_w    = {{(EXT_W-10){1'b0}}, read_index};
    assign rd_in_range = rd_idx_w < DEPTH_W;

    // station address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg <= STATION_RESET;
        end
        else if (cfg_we)
        begin
            station_reg <= cfg_wdata;
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            addr_reg   <= '0;
            length_reg <= '0;
            type_reg   <= '0;
            count_reg  <= '0;
            crc_reg    <= '0;
            crc_lo_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            addr_reg   <= addr_next;
            length_reg <= length_next;
            type_reg   <= type_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    // next state, result and RAM request
    always_comb
    begin
        phase_next  = phase_reg;
        addr_next   = addr_reg;
        length_next = length_reg;
        type_next   = type_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;

        item_valid    = 1'b0;
        item.kind     = KIND_REPORT;
        item.status   = ST_OK;
        item.address  = addr_reg;
        item.ftype    = type_reg;
        item.length   = length_reg;
        item.rd_zero  = 1'b0;
        ram_ctl.wr_en = 1'b0;
        ram_ctl.rd_en = 1'b0;
        ram_addr      = count_w[AW-1:0];
        ram_wdata     = rx_byte;

        if (in_fire && (cmd == CMD_READ))
        begin
            // buffer read: header fields go out as zero
            item_valid    = 1'b1;
            item.kind     = KIND_READ;
            item.address  = '0;
            item.ftype    = '0;
            item.length   = '0;
            item.rd_zero  = !rd_in_range;
            ram_ctl.rd_en = rd_in_range;
            ram_addr      = rd_idx_w[AW-1:0];
        end
        else if (line_fire)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SYNC_BYTE)
                    begin
                        crc_next   = crc16_byte(16'h0000, rx_byte);
                        phase_next = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    addr_next  = rx_byte;
                    crc_next   = crc_upd;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {8'h00, rx_byte};
                    crc_next    = crc_upd;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_next = {rx_byte, length_reg[7:0]};
                    crc_next    = crc_upd;
                    phase_next  = PH_TYPE;
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    crc_next   = crc_upd;
                    count_next = '0;
                    phase_next = (length_reg != 16'd0) ? PH_DATA : PH_CRC_LO;
                end
                PH_DATA:
                begin
                    // bytes past the buffer are counted and hashed only
                    crc_next      = crc_upd;
                    ram_ctl.wr_en = count_w < DEPTH_W;
                    count_next    = count_inc;
                    if (count_inc >= length_reg)
                    begin
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = rx_byte;
                    phase_next  = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    item_valid = 1'b1;
                    if (addr_reg != station_reg && addr_reg != BROADCAST_ADDR)
                    begin
                        item.status = ST_OTHER_ADDR;
                    end
                    else if (rx_crc != crc_reg)
                    begin
                        item.status = ST_CRC_ERR;
                    end
                    else if ({1'b0, length_reg} > DEPTH_W)
                    begin
                        item.status = ST_OVERLONG;
                    end
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    `AFD_ASSERT_NOW(a_wr_only_in_data, ram_ctl.wr_en, line_fire && phase_reg == PH_DATA)
    `AFD_ASSERT_NOW(a_one_ram_access, ram_ctl.wr_en || ram_ctl.rd_en, !(ram_ctl.wr_en && ram_ctl.rd_en))
    `AFD_ASSERT_NOW(a_item_needs_fire, item_valid, in_fire)
    `AFD_ASSERT_NEXT(a_report_rearms, line_fire && phase_reg == PH_CRC_HI, phase_reg == PH_HUNT)

endmodule

// ===== hdl/afd_out_stage.sv =====
// Result pipeline: RAM-aligned result stage and the master-side output register.
// Uses afd_pkg and the assertion macros header.
`include "addressed_frame_deframer_crc16_core_macros.svh"

module afd_out_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  afd_pkg::afd_item_t                 item,
    input  logic [7:0]                         ram_rdata,
    output logic                               in_ready,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [afd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tuser
);
    import afd_pkg::*;

    afd_item_t              s1_item_reg;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic                   out_kind_reg;
    logic                   adv;
    logic [7:0]             rd_byte;

    // stage 1 moves on when the output register is free or being taken
    assign adv      = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign in_ready = !s1_valid_reg || adv;
    assign rd_byte  = (s1_item_reg.kind == KIND_READ && !s1_item_reg.rd_zero) ? ram_rdata : 8'h00;

    // valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_valid)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage 1 payload, lines up with the RAM read data
    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            s1_item_reg <= item;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_kind_reg <= s1_item_reg.kind;
            out_data_reg <= {6'b000000, rd_byte, s1_item_reg.length, s1_item_reg.ftype,
                             s1_item_reg.address, s1_item_reg.status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    `AFD_ASSERT_NEXT(a_s1_kept, s1_valid_reg && !adv, s1_valid_reg)
    `AFD_ASSERT_NOW(a_stall_means_full, !in_ready, s1_valid_reg && out_valid_reg)
    `AFD_ASSERT_NOW(a_item_when_ready, item_valid, in_ready)
    `AFD_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_reg)

endmodule

// ===== hdl/addressed_frame_deframer_crc16_core.sv =====
// CRC-16 addressed frame deframer: one word per cycle when ready, line byte or buffer read.
// A result word passes the stage-1 register and the output register before the master port.
// One word per cycle unless m_axis_tready stalls; the payload RAM takes one access per cycle.
// Line bytes that end no frame produce no result word.
// Reset (rst_n, async, low): parser state, CRC, header registers, valids; station = 20.
// The payload buffer is not cleared; a read returns the entry as it stands, written or not.
module addressed_frame_deframer_crc16_core #(
    parameter int BUF_DEPTH = afd_pkg::BUF_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: station address
    input  logic                           cfg_we,
    input  logic [7:0]                     cfg_wdata,
    // input words
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [afd_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // rx_byte[7:0], read_index[17:8]
    input  logic                           s_axis_tuser,  // cmd
    // result words
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // frame_status[1:0], frame_address[9:2], frame_type[17:10], frame_length[33:18],
    // read_data[41:34]
    output logic [afd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser   // result_kind
);
    import afd_pkg::*;

    localparam int AW = $clog2(BUF_DEPTH);

    logic         in_fire;
    logic         item_valid;
    afd_item_t    item;
    afd_ram_ctl_t ram_ctl;
    logic [AW-1:0] ram_addr;
    logic [7:0]   ram_wdata;
    logic [7:0]   ram_rdata;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    afd_parser #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_fire    (in_fire),
        .cmd        (s_axis_tuser),
        .rx_byte    (s_axis_tdata[7:0]),
        .read_index (s_axis_tdata[17:8]),
        .item_valid (item_valid),
        .item       (item),
        .ram_ctl    (ram_ctl),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata)
    );

    afd_payload_ram #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    afd_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .ram_rdata     (ram_rdata),
        .in_ready      (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
